// ----- rtl/fopre_pkg.sv -----
// Shared constants, types and arithmetic helpers for the pre-emphasis filter.
`timescale 1ns / 1ps

package fopre_pkg;

  localparam int SampleWidth  = 16;
  localparam int CoefFracBits = 16;
  localparam int CoefWidth    = 24;

  // Fed-back output: integer sample bits plus the coefficient fraction bits.
  localparam int AccWidth  = SampleWidth + CoefFracBits;
  // Feedforward sum a0*x + a1*x_prev.
  localparam int FfWidth   = CoefWidth + SampleWidth + 1;
  // Full lane sum before saturation.
  localparam int SumWidth  = (CoefWidth + SampleWidth + 2 > AccWidth) ?
                             (CoefWidth + SampleWidth + 2) : (AccWidth + 1);
  localparam int CfgAddrWidth = 2;
  localparam int DataWidth    = ((2 * SampleWidth + 7) / 8) * 8;

  typedef enum logic [CfgAddrWidth-1:0] {
    CFG_COEF_A0 = 2'd0,
    CFG_COEF_A1 = 2'd1,
    CFG_COEF_FB = 2'd2,
    CFG_IQ_MODE = 2'd3
  } cfg_addr_e;

  typedef struct packed {
    logic signed [CoefWidth-1:0] a0;
    logic signed [CoefWidth-1:0] a1;
    logic signed [CoefWidth-1:0] fb;
  } coef_t;

  // Clamp the wide lane sum into the stored feedback format.
  function automatic logic signed [AccWidth-1:0] sat_acc(input logic signed [SumWidth-1:0] v);
    logic [SumWidth-AccWidth:0] top;
    top = v[SumWidth-1:AccWidth-1];
    if ((&top) || !(|top)) begin
      return v[AccWidth-1:0];
    end else if (v[SumWidth-1]) begin
      return {1'b1, {(AccWidth-1){1'b0}}};
    end else begin
      return {1'b0, {(AccWidth-1){1'b1}}};
    end
  endfunction

  // Drop the fraction bits rounding toward zero, then clamp to a sample.
  function automatic logic signed [SampleWidth-1:0] to_sample(
      input logic signed [AccWidth-1:0] v);
    logic signed [AccWidth:0]      biased;
    logic signed [SampleWidth:0]   whole;
    biased = (AccWidth + 1)'(v);
    if (v[AccWidth-1]) begin
      biased = biased + (AccWidth + 1)'({CoefFracBits{1'b1}});
    end
    whole = biased[AccWidth:CoefFracBits];
    if (whole[SampleWidth] == whole[SampleWidth-1]) begin
      return whole[SampleWidth-1:0];
    end else if (whole[SampleWidth]) begin
      return {1'b1, {(SampleWidth-1){1'b0}}};
    end else begin
      return {1'b0, {(SampleWidth-1){1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/fopre_cfg_regs.sv -----
// Coefficient and mode registers behind the plain write port.
`timescale 1ns / 1ps

module fopre_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fopre_pkg::CfgAddrWidth-1:0]   cfg_addr_i,
  input  logic [fopre_pkg::CoefWidth-1:0]      cfg_data_i,
  output fopre_pkg::coef_t                     coef_o,
  output logic                                 iq_mode_o
);

  fopre_pkg::coef_t coef_q;
  logic             iq_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.a0 <= fopre_pkg::CoefWidth'(1 << fopre_pkg::CoefFracBits);
      coef_q.a1 <= '0;
      coef_q.fb <= '0;
      iq_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (fopre_pkg::cfg_addr_e'(cfg_addr_i))
        fopre_pkg::CFG_COEF_A0: coef_q.a0 <= cfg_data_i;
        fopre_pkg::CFG_COEF_A1: coef_q.a1 <= cfg_data_i;
        fopre_pkg::CFG_COEF_FB: coef_q.fb <= cfg_data_i;
        fopre_pkg::CFG_IQ_MODE: iq_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign coef_o    = coef_q;
  assign iq_mode_o = iq_mode_q;

endmodule

// ----- rtl/fopre_lane.sv -----
// One filter lane: feedforward stage, then feedback stage with the output register.
`timescale 1ns / 1ps

module fopre_lane (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  fopre_pkg::coef_t                            coef_i,
  input  logic signed [fopre_pkg::SampleWidth-1:0]    x_i,
  input  logic                                        load_i,
  input  logic                                        step_i,
  output logic signed [fopre_pkg::SampleWidth-1:0]    y_o
);

  localparam int SW = fopre_pkg::SampleWidth;
  localparam int CW = fopre_pkg::CoefWidth;
  localparam int FB = fopre_pkg::CoefFracBits;

  logic signed [SW-1:0]                    last_in_q;
  logic signed [fopre_pkg::FfWidth-1:0]    ff_d, ff_q;
  logic signed [CW+SW-1:0]                 prod_a0, prod_a1;
  logic signed [fopre_pkg::AccWidth-1:0]   y_d, y_q;
  logic signed [SW-1:0]                    out_q;
  logic signed [SW-1:0]                    y_hi;
  logic signed [FB:0]                      y_lo;
  logic signed [CW+SW-1:0]                 fb_hi;
  logic signed [CW+FB:0]                   fb_lo;
  logic signed [CW:0]                      fb_lo_sh;
  logic signed [fopre_pkg::SumWidth-1:0]   sum;

  // Feedforward part uses only the new and the previous input.
  always_comb begin
    prod_a0 = coef_i.a0 * x_i;
    prod_a1 = coef_i.a1 * last_in_q;
    ff_d    = fopre_pkg::FfWidth'(prod_a0) + fopre_pkg::FfWidth'(prod_a1);
  end

  // Feedback product split in a signed high half and an unsigned low half;
  // only the low half loses bits to the floor.
  always_comb begin
    y_hi     = y_q[fopre_pkg::AccWidth-1:FB];
    y_lo     = {1'b0, y_q[FB-1:0]};
    fb_hi    = coef_i.fb * y_hi;
    fb_lo    = coef_i.fb * y_lo;
    fb_lo_sh = fb_lo[CW+FB:FB];
    sum      = fopre_pkg::SumWidth'(ff_q) + fopre_pkg::SumWidth'(fb_hi)
             + fopre_pkg::SumWidth'(fb_lo_sh);
    y_d      = fopre_pkg::sat_acc(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_in_q <= '0;
      y_q       <= '0;
    end else begin
      if (load_i) begin
        last_in_q <= x_i;
      end
      if (step_i) begin
        y_q <= y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ff_q <= ff_d;
    end
    if (step_i) begin
      out_q <= fopre_pkg::to_sample(y_d);
    end
  end

  assign y_o = out_q;

endmodule

// ----- rtl/first_order_iir_preemphasis_core.sv -----
// Top level of the first-order IIR pre-emphasis filter with stream handshakes.
// Each accepted item passes the feedforward register and then the output register.
// Throughput: one item per cycle while the output is not stalled.
// The feedback stage (two coefficient products and a three-term add) sets the clock.
// Reset clears the pipeline valids, the lane history and loads the default coefficients.
// Input ready drops only while a finished result waits at a stalled output.
`timescale 1ns / 1ps

module first_order_iir_preemphasis_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [fopre_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [fopre_pkg::CoefWidth-1:0]     cfg_data_i,
  // Input items.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fopre_pkg::DataWidth-1:0]     s_axis_tdata,  // sample_i, sample_q
  // Result items.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fopre_pkg::DataWidth-1:0]     m_axis_tdata   // out_i, out_q
);

  localparam int SW = fopre_pkg::SampleWidth;

  // Control that travels with an item through the two stages.
  typedef struct packed {
    logic valid;
    logic iq;
  } stage_t;

  fopre_pkg::coef_t      coef;
  logic                  iq_mode;
  logic                  advance;
  stage_t                ff_stage_q, out_stage_q;
  logic signed [SW-1:0]  y_i, y_q;

  fopre_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef),
    .iq_mode_o  (iq_mode)
  );

  // The whole pipeline moves together whenever the output register is free
  // or is being emptied this cycle; bubbles simply ride along.
  assign advance       = !out_stage_q.valid || m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_stage_q  <= '0;
      out_stage_q <= '0;
    end else if (advance) begin
      ff_stage_q.valid <= s_axis_tvalid;
      ff_stage_q.iq    <= iq_mode;
      out_stage_q      <= ff_stage_q;
    end
  end

  // The in-phase lane always runs. The quadrature lane runs only in I/Q mode,
  // so in scalar mode its history holds for when I/Q mode returns.
  fopre_lane u_lane_i (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .x_i    (s_axis_tdata[SW-1:0]),
    .load_i (advance && s_axis_tvalid),
    .step_i (advance && ff_stage_q.valid),
    .y_o    (y_i)
  );

  fopre_lane u_lane_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .x_i    (s_axis_tdata[2*SW-1:SW]),
    .load_i (advance && s_axis_tvalid && iq_mode),
    .step_i (advance && ff_stage_q.valid && ff_stage_q.iq),
    .y_o    (y_q)
  );

  assign m_axis_tvalid = out_stage_q.valid;
  assign m_axis_tdata  = fopre_pkg::DataWidth'({(out_stage_q.iq ? y_q : {SW{1'b0}}), y_i});

endmodule
